// ----- sv/mbl_pkg.sv -----
package mbl_pkg;

  // Default sizes of the mask store and of the largest target image.
  localparam int unsigned MASK_MAX_WIDTH_DEF  = 256;
  localparam int unsigned MASK_MAX_HEIGHT_DEF = 256;
  localparam int unsigned IMAGE_MAX_DIM_DEF   = 4096;

  // Fixed field widths.
  localparam int unsigned POS_W      = 12;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned TDIM_W     = 13;
  localparam int unsigned MDIM_W     = 9;
  localparam int unsigned OPA_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned FRAC_W     = 16;

  // Q16 constants.
  localparam logic [OPA_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [OPA_W-1:0] HALF_Q16 = 17'd32768;

  // Rounding offset and reciprocal for the division by 255 * 65536.
  localparam logic [40:0] ROUND_255 = 41'd8355840;
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_WIDTH  = 3'd0,
    CFG_TARGET_HEIGHT = 3'd1,
    CFG_MASK_WIDTH    = 3'd2,
    CFG_MASK_HEIGHT   = 3'd3,
    CFG_INVERT_MASK   = 3'd4,
    CFG_OPACITY_LEVEL = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_BLEND = 1'b1
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [CH_W-1:0]  mask_byte;
    logic [CH_W-1:0]  src_red;
    logic [CH_W-1:0]  src_green;
    logic [CH_W-1:0]  src_blue;
    logic [CH_W-1:0]  dst_red;
    logic [CH_W-1:0]  dst_green;
    logic [CH_W-1:0]  dst_blue;
  } item_t;

endpackage

// ----- sv/mbl_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits, so the numerator bits above QW are
// already smaller than the divisor.
module mbl_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned QW = 24,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] bits_q [QW+1];
  logic [NW-1:0] num_hi;

  assign num_hi = num_i >> QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_hi[DW-1:0];
      den_q[0]  <= den_i;
      bits_q[0] <= num_i[QW-1:0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_q[k], bits_q[k][QW-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bits_q[k+1] <= {bits_q[k][QW-2:0], ge};
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quo_o = bits_q[QW];

endmodule

// ----- sv/masked_selection_alpha_blend.sv -----
// Masked selection alpha blend. Load beats (action 0) write one byte of the
// selection mask at (x_pos, y_pos); blend beats (action 1) map the target
// pixel into mask space in Q16, interpolate the four neighboring mask bytes
// bilinearly, optionally invert the result, scale it by the opacity and mix
// the source color over the destination color, giving one result beat with
// alpha 255. Load beats give no result. The design is a single stalling
// pipeline that takes one beat in every cycle while it is not stalled.
// Bit-per-stage dividers map x and y into mask space. When the output
// register holds a result that the receiver stalls, the whole pipeline
// holds and in_stall_o rises; otherwise beats flow in and out at one per
// clock. The mask lives in four banks split by the parity of the column
// and the row, so the four bilinear taps are read together. A mask write
// travels down the pipeline and reaches the banks at the same stage where
// blends read them, so each blend sees exactly the loads that were
// accepted before it. Mask entries that were never written read as
// arbitrary values. Configuration registers must only be written while
// the pipeline is empty.
module masked_selection_alpha_blend import mbl_pkg::*; #(
  parameter int unsigned MASK_MAX_WIDTH  = MASK_MAX_WIDTH_DEF,
  parameter int unsigned MASK_MAX_HEIGHT = MASK_MAX_HEIGHT_DEF,
  parameter int unsigned IMAGE_MAX_DIM   = IMAGE_MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [POS_W-1:0]      x_pos_i,
  input  logic [POS_W-1:0]      y_pos_i,
  input  logic [CH_W-1:0]       mask_byte_i,
  input  logic [CH_W-1:0]       src_red_i,
  input  logic [CH_W-1:0]       src_green_i,
  input  logic [CH_W-1:0]       src_blue_i,
  input  logic [CH_W-1:0]       dst_red_i,
  input  logic [CH_W-1:0]       dst_green_i,
  input  logic [CH_W-1:0]       dst_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic [CH_W-1:0]       out_alpha_o
);

  // Mask coordinate widths and the common quotient width of both dividers.
  localparam int unsigned MXW = $clog2(MASK_MAX_WIDTH);
  localparam int unsigned MYW = $clog2(MASK_MAX_HEIGHT);
  localparam int unsigned MW  = (MXW > MYW) ? MXW : MYW;
  localparam int unsigned QW  = MW + FRAC_W;
  localparam int unsigned DW  = $clog2(IMAGE_MAX_DIM);
  localparam int unsigned PW  = POS_W + MW;
  localparam int unsigned NW  = PW + FRAC_W;
  localparam int unsigned LAT = QW + 1;

  // Bank geometry: one extra column and row so the right or lower
  // neighbor of the last entry still has an address.
  localparam int unsigned COLS  = MASK_MAX_WIDTH / 2 + 1;
  localparam int unsigned ROWS  = MASK_MAX_HEIGHT / 2 + 1;
  localparam int unsigned DEPTH = COLS * ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [TDIM_W-1:0] tw_q, th_q;
  logic [MDIM_W-1:0] mw_q, mh_q;
  logic              inv_q;
  logic [OPA_W-1:0]  op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= TDIM_W'(1);
      th_q  <= TDIM_W'(1);
      mw_q  <= MDIM_W'(1);
      mh_q  <= MDIM_W'(1);
      inv_q <= 1'b0;
      op_q  <= ONE_Q16;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_WIDTH:  tw_q  <= cfg_wdata_i[TDIM_W-1:0];
        CFG_TARGET_HEIGHT: th_q  <= cfg_wdata_i[TDIM_W-1:0];
        CFG_MASK_WIDTH:    mw_q  <= cfg_wdata_i[MDIM_W-1:0];
        CFG_MASK_HEIGHT:   mh_q  <= cfg_wdata_i[MDIM_W-1:0];
        CFG_INVERT_MASK:   inv_q <= cfg_wdata_i[0];
        CFG_OPACITY_LEVEL: op_q  <= cfg_wdata_i[OPA_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize saturates.
  logic [DW:0]    twc, thc, twm1, thm1;
  logic [DW-1:0]  dxm1, dym1;
  logic [MXW:0]   mwc, mwp;
  logic [MYW:0]   mhc, mhp;
  logic [MXW-1:0] mwm1;
  logic [MYW-1:0] mhm1;

  always_comb begin
    if (tw_q == '0)                 twc = (DW+1)'(1);
    else if (tw_q > IMAGE_MAX_DIM)  twc = (DW+1)'(IMAGE_MAX_DIM);
    else                            twc = (DW+1)'(tw_q);
    if (th_q == '0)                 thc = (DW+1)'(1);
    else if (th_q > IMAGE_MAX_DIM)  thc = (DW+1)'(IMAGE_MAX_DIM);
    else                            thc = (DW+1)'(th_q);
    if (mw_q == '0)                 mwc = (MXW+1)'(1);
    else if (mw_q > MASK_MAX_WIDTH) mwc = (MXW+1)'(MASK_MAX_WIDTH);
    else                            mwc = (MXW+1)'(mw_q);
    if (mh_q == '0)                  mhc = (MYW+1)'(1);
    else if (mh_q > MASK_MAX_HEIGHT) mhc = (MYW+1)'(MASK_MAX_HEIGHT);
    else                             mhc = (MYW+1)'(mh_q);
  end

  assign twm1 = twc - (DW+1)'(1);
  assign thm1 = thc - (DW+1)'(1);
  assign dxm1 = twm1[DW-1:0];
  assign dym1 = thm1[DW-1:0];
  assign mwp  = mwc - (MXW+1)'(1);
  assign mhp  = mhc - (MYW+1)'(1);
  assign mwm1 = mwp[MXW-1:0];
  assign mhm1 = mhp[MYW-1:0];

  // ------------------------------------------------------------------
  // Handshake: the pipeline moves as a whole unless a result is stalled.
  // ------------------------------------------------------------------
  logic en;
  logic out_v_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  item_t in_item;
  assign in_item = '{action:    action_e'(action_i),
                     x_pos:     x_pos_i,
                     y_pos:     y_pos_i,
                     mask_byte: mask_byte_i,
                     src_red:   src_red_i,
                     src_green: src_green_i,
                     src_blue:  src_blue_i,
                     dst_red:   dst_red_i,
                     dst_green: dst_green_i,
                     dst_blue:  dst_blue_i};

  // ------------------------------------------------------------------
  // Stage 1: clamp the pixel into the target and form p * (m - 1).
  // ------------------------------------------------------------------
  logic [POS_W-1:0] xc, yc;
  logic [PW-1:0]    xce, yce, mwe, mhe, px, py;
  logic [DW-1:0]    denx, deny;

  assign xc   = (x_pos_i > dxm1) ? POS_W'(dxm1) : x_pos_i;
  assign yc   = (y_pos_i > dym1) ? POS_W'(dym1) : y_pos_i;
  assign xce  = PW'(xc);
  assign yce  = PW'(yc);
  assign mwe  = PW'(mwm1);
  assign mhe  = PW'(mhm1);
  assign px   = xce * mwe;
  assign py   = yce * mhe;
  // A one-pixel target has its position forced to zero, so any nonzero
  // divisor gives the zero coordinate.
  assign denx = (dxm1 == '0) ? DW'(1) : dxm1;
  assign deny = (dym1 == '0) ? DW'(1) : dym1;

  logic          s1_v_q;
  item_t         s1_it_q;
  logic [NW-1:0] s1_numx_q, s1_numy_q;
  logic [DW-1:0] s1_denx_q, s1_deny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_it_q   <= in_item;
      s1_numx_q <= {px, FRAC_W'(0)};
      s1_numy_q <= {py, FRAC_W'(0)};
      s1_denx_q <= denx;
      s1_deny_q <= deny;
    end
  end

  // ------------------------------------------------------------------
  // Mapping dividers, with the beat riding alongside.
  // ------------------------------------------------------------------
  logic [QW-1:0] qx, qy;

  mbl_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s1_numx_q),
    .den_i (s1_denx_q),
    .quo_o (qx)
  );

  mbl_div #(.NW(NW), .QW(QW), .DW(DW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s1_numy_q),
    .den_i (s1_deny_q),
    .quo_o (qy)
  );

  logic  dl_v_q  [LAT];
  item_t dl_it_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) dl_v_q[i] <= 1'b0;
    end else if (en) begin
      dl_v_q[0] <= s1_v_q;
      for (int i = 1; i < LAT; i++) dl_v_q[i] <= dl_v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_it_q[0] <= s1_it_q;
      for (int i = 1; i < LAT; i++) dl_it_q[i] <= dl_it_q[i-1];
    end
  end

  // ------------------------------------------------------------------
  // Stage C: split the Q16 coordinates into tap index and fraction.
  // ------------------------------------------------------------------
  logic [MW-1:0]  qhx, qhy;
  logic [MXW-1:0] x0;
  logic [MYW-1:0] y0;

  assign qhx = qx[QW-1:FRAC_W];
  assign qhy = qy[QW-1:FRAC_W];
  assign x0  = (qhx > mwm1) ? mwm1 : qhx[MXW-1:0];
  assign y0  = (qhy > mhm1) ? mhm1 : qhy[MYW-1:0];

  logic              sc_v_q;
  item_t             sc_it_q;
  logic [MXW-1:0]    sc_x0_q;
  logic [MYW-1:0]    sc_y0_q;
  logic              sc_xe_q, sc_ye_q;
  logic [FRAC_W-1:0] sc_tx_q, sc_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sc_v_q <= 1'b0;
    else if (en) sc_v_q <= dl_v_q[LAT-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_it_q <= dl_it_q[LAT-1];
      sc_x0_q <= x0;
      sc_y0_q <= y0;
      sc_xe_q <= (x0 == mwm1);
      sc_ye_q <= (y0 == mhm1);
      sc_tx_q <= qx[FRAC_W-1:0];
      sc_ty_q <= qy[FRAC_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Stage R: mask banks. Bank index is {row parity, column parity}.
  // Even banks read x0 + 1 when x0 is odd and x0 when it is even; odd banks
  // the reverse. Together they always hold columns x0 and x0 + 1.
  // ------------------------------------------------------------------
  logic [MXW:0] x0p;
  logic [MYW:0] y0p;
  logic [CW-1:0] col_even, col_odd;
  logic [RW-1:0] row_even, row_odd;
  logic [AW-1:0] raddr [4];

  assign x0p      = {1'b0, sc_x0_q} + (MXW+1)'(1);
  assign y0p      = {1'b0, sc_y0_q} + (MYW+1)'(1);
  assign col_even = CW'(x0p[MXW:1]);
  assign col_odd  = CW'(sc_x0_q >> 1);
  assign row_even = RW'(y0p[MYW:1]);
  assign row_odd  = RW'(sc_y0_q >> 1);

  assign raddr[0] = AW'(row_even * COLS + col_even);
  assign raddr[1] = AW'(row_even * COLS + col_odd);
  assign raddr[2] = AW'(row_odd * COLS + col_even);
  assign raddr[3] = AW'(row_odd * COLS + col_odd);

  logic          wr_act;
  logic [1:0]    wr_bank;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;

  assign wr_act  = sc_v_q && (sc_it_q.action == ACT_LOAD) &&
                   (sc_it_q.x_pos < MASK_MAX_WIDTH) &&
                   (sc_it_q.y_pos < MASK_MAX_HEIGHT);
  assign wr_bank = {sc_it_q.y_pos[0], sc_it_q.x_pos[0]};
  assign wcol    = CW'(sc_it_q.x_pos >> 1);
  assign wrow    = RW'(sc_it_q.y_pos >> 1);
  assign waddr   = AW'(wrow * COLS + wcol);

  logic [3:0][CH_W-1:0] rd_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CH_W-1:0] mem [DEPTH];

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (wr_act && (wr_bank == 2'(b))) begin
          mem[waddr] <= sc_it_q.mask_byte;
        end
        rd_q[b] <= mem[raddr[b]];
      end
    end
  end

  logic              sr_v_q;
  item_t             sr_it_q;
  logic              sr_xs_q, sr_ys_q, sr_xe_q, sr_ye_q;
  logic [FRAC_W-1:0] sr_tx_q, sr_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sr_v_q <= 1'b0;
    else if (en) sr_v_q <= sc_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_it_q <= sc_it_q;
      sr_xs_q <= sc_x0_q[0];
      sr_ys_q <= sc_y0_q[0];
      sr_xe_q <= sc_xe_q;
      sr_ye_q <= sc_ye_q;
      sr_tx_q <= sc_tx_q;
      sr_ty_q <= sc_ty_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: pick the four taps and interpolate along x.
  // At the right or lower mask edge the far tap repeats the near one.
  // ------------------------------------------------------------------
  logic            bx1, by1;
  logic [CH_W-1:0] row0_x0, row0_x1, row1_x0, row1_x1;
  logic [CH_W-1:0] p00, p10, p01, p11;

  assign bx1 = sr_xe_q ? sr_xs_q : !sr_xs_q;
  assign by1 = sr_ye_q ? sr_ys_q : !sr_ys_q;

  // Taps of row y0 and row y1 for the two column parities.
  assign row0_x0 = sr_ys_q ? (sr_xs_q ? rd_q[3] : rd_q[2]) : (sr_xs_q ? rd_q[1] : rd_q[0]);
  assign row0_x1 = sr_ys_q ? (bx1 ? rd_q[3] : rd_q[2]) : (bx1 ? rd_q[1] : rd_q[0]);
  assign row1_x0 = by1 ? (sr_xs_q ? rd_q[3] : rd_q[2]) : (sr_xs_q ? rd_q[1] : rd_q[0]);
  assign row1_x1 = by1 ? (bx1 ? rd_q[3] : rd_q[2]) : (bx1 ? rd_q[1] : rd_q[0]);

  assign p00 = row0_x0;
  assign p10 = row0_x1;
  assign p01 = row1_x0;
  assign p11 = row1_x1;

  logic signed [CH_W:0] dab, dcd;
  logic signed [26:0]   a_w, b_w;

  assign dab = $signed({1'b0, p10}) - $signed({1'b0, p00});
  assign dcd = $signed({1'b0, p11}) - $signed({1'b0, p01});
  assign a_w = $signed({3'b000, p00, FRAC_W'(0)}) + dab * $signed({1'b0, sr_tx_q});
  assign b_w = $signed({3'b000, p01, FRAC_W'(0)}) + dcd * $signed({1'b0, sr_tx_q});

  logic              s2_v_q;
  item_t             s2_it_q;
  logic [23:0]       s2_a_q, s2_b_q;
  logic [FRAC_W-1:0] s2_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= sr_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_it_q <= sr_it_q;
      s2_a_q  <= a_w[23:0];
      s2_b_q  <= b_w[23:0];
      s2_ty_q <= sr_ty_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: interpolate along y (the result is never negative).
  // ------------------------------------------------------------------
  logic signed [24:0] dba;
  logic signed [42:0] v_w;

  assign dba = $signed({1'b0, s2_b_q}) - $signed({1'b0, s2_a_q});
  assign v_w = $signed({3'b000, s2_a_q, FRAC_W'(0)}) + dba * $signed({1'b0, s2_ty_q});

  logic        s3_v_q;
  item_t       s3_it_q;
  logic [39:0] s3_v_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_it_q    <= s2_it_q;
      s3_v_val_q <= v_w[39:0];
    end
  end

  // ------------------------------------------------------------------
  // Stages 4 and 5: alpha = round(v / (255 * 65536)). The low 16 bits are
  // dropped first, then the division by 255 is a multiply by a rounded-up
  // reciprocal, exact for every value below 2^24.
  // ------------------------------------------------------------------
  logic [40:0] vr;

  assign vr = {1'b0, s3_v_val_q} + ROUND_255;

  logic        s4_v_q;
  item_t       s4_it_q;
  logic [23:0] s4_u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_it_q <= s3_it_q;
      s4_u_q  <= vr[39:16];
    end
  end

  logic [48:0] recip_prod;

  assign recip_prod = {25'd0, s4_u_q} * {24'd0, RECIP_255};

  logic             s5_v_q;
  item_t            s5_it_q;
  logic [OPA_W-1:0] s5_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_it_q    <= s4_it_q;
      s5_alpha_q <= recip_prod[48:32];
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: optional inversion and opacity scaling, rounded half up.
  // ------------------------------------------------------------------
  logic [OPA_W-1:0] alpha_m, opc;
  logic [33:0]      scaled;

  assign alpha_m = inv_q ? (ONE_Q16 - s5_alpha_q) : s5_alpha_q;
  assign opc     = (op_q > ONE_Q16) ? ONE_Q16 : op_q;
  assign scaled  = {17'd0, alpha_m} * {17'd0, opc} + {17'd0, HALF_Q16};

  logic             s6_v_q;
  item_t            s6_it_q;
  logic [OPA_W-1:0] s6_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_it_q    <= s5_it_q;
      s6_alpha_q <= scaled[32:16];
    end
  end

  // ------------------------------------------------------------------
  // Output stage: mix each channel and hold the result beat. Only blend
  // beats become results; loads drop out here.
  // ------------------------------------------------------------------
  logic [OPA_W-1:0] alpha_n;
  logic [24:0]      mix_r, mix_g, mix_b;

  assign alpha_n = ONE_Q16 - s6_alpha_q;
  assign mix_r = {17'd0, s6_it_q.src_red} * {8'd0, s6_alpha_q} +
                 {17'd0, s6_it_q.dst_red} * {8'd0, alpha_n} + {8'd0, HALF_Q16};
  assign mix_g = {17'd0, s6_it_q.src_green} * {8'd0, s6_alpha_q} +
                 {17'd0, s6_it_q.dst_green} * {8'd0, alpha_n} + {8'd0, HALF_Q16};
  assign mix_b = {17'd0, s6_it_q.src_blue} * {8'd0, s6_alpha_q} +
                 {17'd0, s6_it_q.dst_blue} * {8'd0, alpha_n} + {8'd0, HALF_Q16};

  logic [CH_W-1:0] out_r_q, out_g_q, out_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s6_v_q && (s6_it_q.action == ACT_BLEND);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_r_q <= mix_r[23:16];
      out_g_q <= mix_g[23:16];
      out_b_q <= mix_b[23:16];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_red_o   = out_r_q;
  assign out_green_o = out_g_q;
  assign out_blue_o  = out_b_q;
  assign out_alpha_o = ALPHA_OPAQUE;

endmodule
